/* src/qra_pkg.sv */
// Package with the types, constants and helper functions of the quaternion rotation accumulator.
package qra_pkg;

  localparam int unsigned CompW        = 16;
  localparam int unsigned ProdW        = 2 * CompW;
  localparam int unsigned AccW         = ProdW + 3;
  localparam int unsigned IntervalW    = 8;
  localparam logic [IntervalW-1:0] IntervalReset = 8'd100;
  localparam logic signed [CompW-1:0] QOne = 16'sd16384;
  localparam int unsigned FracBits     = 14;
  localparam int unsigned SqW          = 34;
  localparam int unsigned RootW        = SqW / 2;
  localparam int unsigned DivW         = 32;
  localparam int unsigned CfgIdxW      = 1;

  typedef enum logic [1:0] {
    MODE_ACC   = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_KEEP  = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    CFG_INTERVAL  = 1'b0,
    CFG_TRANSPOSE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_QSTORE,
    ST_SUMSQ,
    ST_SQRT,
    ST_DIV,
    ST_DSTORE,
    ST_MAT,
    ST_EMIT
  } state_e;

  typedef logic signed [CompW-1:0] comp_t;

  // Q4.28 sum to Q2.14: add half, arithmetic shift (floor), saturate.
  function automatic comp_t round_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic signed [AccW-1:0] q;
    t = v + AccW'(signed'(1 <<< (FracBits - 1)));
    q = t >>> FracBits;
    if (q > AccW'(32767)) begin
      return 16'sh7fff;
    end else if (q < -AccW'(32768)) begin
      return 16'sh8000;
    end
    return q[CompW-1:0];
  endfunction

endpackage

/* src/qra_div.sv */
// Restoring divider, one quotient bit per cycle.
module qra_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [qra_pkg::DivW-1:0] num_i,
  input  logic [qra_pkg::DivW-1:0] den_i,
  output logic                     done_o,
  output logic [qra_pkg::DivW-1:0] quo_o
);
  import qra_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DivW:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[DivW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = DivW'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DivW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  // The quotient is held in quo_q from the cycle after done_o.
  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = quo_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider still busy after done");
  a_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> den_i != '0) else $error("divide by zero started");
`endif

endmodule

/* src/quaternion_rotation_accumulator_unit.sv */
// Top level of the quaternion rotation accumulator: sequencer, shared multiplier, square root, divider and output.
//
// Usage. Input items arrive on in_valid_i/in_ready_o with mode_i and the four
// quaternion components in Q2.14. Mode 0 premultiplies the held orientation by
// the incoming quaternion, mode 1 loads it, mode 2 clears it to identity and
// mode 3 leaves it alone. Each item gives three result transfers on
// out_valid_o/out_ready_i, rows 0, 1 and 2 of the rotation matrix (or its
// transpose), each carrying the current quaternion; last_row_o marks row 2.
// Timing. One signed 16x16 multiplier is shared by all products and is used
// once per cycle. Load, clear and keep go straight to the matrix products;
// accumulation first forms the quaternion product and, when renormalisation
// fires, the sum of squares, the bit-serial square root and the bit-serial
// divider. Rows then leave one per cycle while the receiver takes them; a
// stall simply holds the current row, and no new item is accepted until the
// third row has been transferred.
// Reset puts the orientation at identity, the counter at zero, the interval
// at 100 and the transpose flag at zero. Configuration writes on
// cfg_valid_i/cfg_ready_o are always taken; index 0 is the interval, index 1
// the transpose flag and other indices are ignored.
module quaternion_rotation_accumulator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  qra_pkg::comp_t      in_x_i,
  input  qra_pkg::comp_t      in_y_i,
  input  qra_pkg::comp_t      in_z_i,
  input  qra_pkg::comp_t      in_w_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          row_index_o,
  output qra_pkg::comp_t      col_a_o,
  output qra_pkg::comp_t      col_b_o,
  output qra_pkg::comp_t      col_c_o,
  output qra_pkg::comp_t      out_x_o,
  output qra_pkg::comp_t      out_y_o,
  output qra_pkg::comp_t      out_z_o,
  output qra_pkg::comp_t      out_w_o,
  output logic                last_row_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import qra_pkg::*;

  // Product schedule: (sel_a, sel_b, sign) for each step. Operand codes 0..3
  // are orientation x,y,z,w; 4..7 are the input x,y,z,w.
  localparam int unsigned QSteps = 16;
  localparam int unsigned MSteps = 12;
  localparam int unsigned StepW  = 4;

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  comp_t            ori_q [4];
  comp_t            in_q  [4];
  comp_t            tmp_q [4];
  comp_t            mat_q [9];
  logic signed [AccW-1:0] acc_q;
  logic signed [ProdW-1:0] prod_q;
  logic             prod_v_q, prod_neg_q;
  logic [IntervalW-1:0] interval_q, ctr_q;
  logic             transpose_q;
  logic [1:0]       row_q;
  logic [SqW-1:0]   sumsq_q;
  logic [SqW-1:0]   sq_rem_q;
  logic [RootW-1:0] root_q;
  logic [4:0]       sq_cnt_q;
  logic [1:0]       comp_idx_q;

  // Shared multiplier operands.
  comp_t op_a, op_b;
  logic  op_neg;
  logic  mul_en;

  function automatic comp_t pick(input logic [2:0] s, input comp_t o [4],
                                 input comp_t n [4]);
    return s[2] ? n[s[1:0]] : o[s[1:0]];
  endfunction

  // Quaternion product new = in * old; four sums of four products each.
  logic [2:0] qa, qb;
  logic       qn;
  always_comb begin
    qa = 3'd0; qb = 3'd0; qn = 1'b0;
    case (step_q)
      4'd0:  begin qa = 3'd0; qb = 3'd7; end
      4'd1:  begin qa = 3'd4; qb = 3'd3; end
      4'd2:  begin qa = 3'd5; qb = 3'd2; end
      4'd3:  begin qa = 3'd6; qb = 3'd1; qn = 1'b1; end
      4'd4:  begin qa = 3'd1; qb = 3'd7; end
      4'd5:  begin qa = 3'd5; qb = 3'd3; end
      4'd6:  begin qa = 3'd6; qb = 3'd0; end
      4'd7:  begin qa = 3'd4; qb = 3'd2; qn = 1'b1; end
      4'd8:  begin qa = 3'd2; qb = 3'd7; end
      4'd9:  begin qa = 3'd6; qb = 3'd3; end
      4'd10: begin qa = 3'd4; qb = 3'd1; end
      4'd11: begin qa = 3'd5; qb = 3'd0; qn = 1'b1; end
      4'd12: begin qa = 3'd7; qb = 3'd3; end
      4'd13: begin qa = 3'd4; qb = 3'd0; qn = 1'b1; end
      4'd14: begin qa = 3'd5; qb = 3'd1; qn = 1'b1; end
      4'd15: begin qa = 3'd6; qb = 3'd2; qn = 1'b1; end
      default: ;
    endcase
  end

  // Matrix products, two per entry class: a=0 b=1 c=2 d=3.
  // Steps: bb, cc, aa, ab, cd, ca, bd, bc, ad; the later steps make no product.
  logic [2:0] ma, mb;
  always_comb begin
    ma = 3'd0; mb = 3'd0;
    case (step_q)
      4'd0: begin ma = 3'd1; mb = 3'd1; end
      4'd1: begin ma = 3'd2; mb = 3'd2; end
      4'd2: begin ma = 3'd0; mb = 3'd0; end
      4'd3: begin ma = 3'd0; mb = 3'd1; end
      4'd4: begin ma = 3'd2; mb = 3'd3; end
      4'd5: begin ma = 3'd2; mb = 3'd0; end
      4'd6: begin ma = 3'd1; mb = 3'd3; end
      4'd7: begin ma = 3'd1; mb = 3'd2; end
      4'd8: begin ma = 3'd0; mb = 3'd3; end
      default: ;
    endcase
  end

  always_comb begin
    op_a = '0; op_b = '0; op_neg = 1'b0; mul_en = 1'b0;
    case (state_q)
      ST_QMUL: begin
        op_a = pick(qa, ori_q, in_q); op_b = pick(qb, ori_q, in_q);
        op_neg = qn; mul_en = 1'b1;
      end
      ST_SUMSQ: begin
        op_a = ori_q[step_q[1:0]]; op_b = ori_q[step_q[1:0]];
        mul_en = (step_q < StepW'(4));
      end
      ST_MAT: begin
        op_a = ori_q[ma[1:0]]; op_b = ori_q[mb[1:0]];
        mul_en = (step_q < StepW'(9));
      end
      default: ;
    endcase
  end

  // Registered shared multiplier.
  always_ff @(posedge clk_i) begin
    prod_q     <= op_a * op_b;
    prod_neg_q <= op_neg;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= mul_en;
    end
  end

  logic signed [AccW-1:0] prod_ext;
  assign prod_ext = prod_neg_q ? -AccW'(prod_q) : AccW'(prod_q);

  // Matrix products are kept for the entry step.
  logic signed [ProdW-1:0] mp_q [9];
  logic [StepW-1:0] pstep_q;
  always_ff @(posedge clk_i) begin
    pstep_q <= step_q;
  end

  // Divider for renormalisation: (|c| * 2^15 + m) / (2m). When a component is
  // stored, the divider is already restarted on the next one.
  logic            div_start, div_done;
  logic [DivW-1:0] div_num, div_den, div_quo;
  comp_t           cur_c;
  logic [1:0]      div_idx;
  comp_t           div_c;
  logic [CompW-1:0] cur_mag;
  assign cur_c   = ori_q[comp_idx_q];
  assign div_idx = (state_q == ST_DSTORE) ? comp_idx_q + 2'd1 : comp_idx_q;
  assign div_c   = ori_q[div_idx];
  assign cur_mag = div_c[CompW-1] ? CompW'(-div_c) : CompW'(div_c);
  assign div_num = DivW'({cur_mag, 15'd0}) + DivW'(root_q);
  assign div_den = DivW'({root_q, 1'b0});

  qra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic accept_in;
  logic renorm_go;
  assign accept_in = in_valid_i && in_ready_o;
  assign renorm_go = (ctr_q + 1'b1) > interval_q || ctr_q == '1;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          step_d  = '0;
          state_d = (mode_i == MODE_ACC) ? ST_QMUL : ST_MAT;
        end
      end
      ST_QMUL: begin
        step_d = step_q + 1'b1;
        if (step_q == StepW'(QSteps - 1)) begin
          state_d = ST_QSTORE;
        end
      end
      ST_QSTORE: begin
        step_d = '0;
        if (prod_v_q == 1'b0) begin
          state_d = renorm_go ? ST_SUMSQ : ST_MAT;
        end
      end
      ST_SUMSQ: begin
        step_d = step_q + 1'b1;
        if (step_q == StepW'(5)) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_cnt_q == 5'd0) begin
          state_d = (root_q == '0) ? ST_MAT : ST_DIV;
          step_d  = '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DSTORE;
        end
      end
      ST_DSTORE: begin
        state_d = (comp_idx_q == 2'd3) ? ST_MAT : ST_DIV;
        step_d  = '0;
      end
      ST_MAT: begin
        step_d = step_q + 1'b1;
        if (step_q == StepW'(MSteps - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i && row_q == 2'd2) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and strobe logic.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    div_start   = 1'b0;
    if (state_q == ST_SQRT && sq_cnt_q == 5'd0 && root_q != '0) begin
      div_start = 1'b1;
    end
    if (state_q == ST_DSTORE && comp_idx_q != 2'd3) begin
      div_start = 1'b1;
    end
  end

  // Bit-serial square root step: try setting root bit i, which costs
  // (4R + 1) * 4^i of the remainder.
  logic [SqW+1:0]   sq_trial;
  assign sq_trial = {2'b0, sq_rem_q}
                  - ((SqW + 2)'({root_q, 2'b01}) << {sq_cnt_q - 5'd1, 1'b0});

  logic signed [AccW-1:0] one_q28;
  assign one_q28 = AccW'(1) <<< (2 * FracBits);

  function automatic logic signed [AccW-1:0] x2(input logic signed [ProdW-1:0] p);
    return AccW'(p) <<< 1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      row_q       <= '0;
      ctr_q       <= '0;
      interval_q  <= IntervalReset;
      transpose_q <= 1'b0;
      ori_q[0]    <= '0;
      ori_q[1]    <= '0;
      ori_q[2]    <= '0;
      ori_q[3]    <= QOne;
      comp_idx_q  <= '0;
      sq_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == 8'(CFG_INTERVAL)) begin
          interval_q <= cfg_data_i[IntervalW-1:0];
        end else if (cfg_index_i == 8'(CFG_TRANSPOSE)) begin
          transpose_q <= cfg_data_i[0];
        end
      end
      if (accept_in) begin
        if (mode_i == MODE_LOAD) begin
          ori_q[0] <= in_x_i; ori_q[1] <= in_y_i;
          ori_q[2] <= in_z_i; ori_q[3] <= in_w_i;
        end else if (mode_i == MODE_CLEAR) begin
          ori_q[0] <= '0; ori_q[1] <= '0; ori_q[2] <= '0; ori_q[3] <= QOne;
        end
      end
      if (state_q == ST_QSTORE && !prod_v_q) begin
        ori_q[0] <= tmp_q[0]; ori_q[1] <= tmp_q[1];
        ori_q[2] <= tmp_q[2]; ori_q[3] <= tmp_q[3];
        ctr_q    <= renorm_go ? '0 : ctr_q + 1'b1;
      end
      if (state_q == ST_SUMSQ && step_q == StepW'(5)) begin
        sq_cnt_q <= 5'(RootW);
      end else if (state_q == ST_SQRT && sq_cnt_q != 5'd0) begin
        sq_cnt_q <= sq_cnt_q - 1'b1;
      end
      if (state_q == ST_SQRT && sq_cnt_q == 5'd0) begin
        comp_idx_q <= '0;
      end
      if (state_q == ST_DSTORE) begin
        ori_q[comp_idx_q] <= cur_c[CompW-1] ?
          ((div_quo > DivW'(32768)) ? 16'sh8000 : CompW'(-div_quo)) :
          ((div_quo > DivW'(32767)) ? 16'sh7fff : CompW'(div_quo));
        comp_idx_q <= comp_idx_q + 1'b1;
      end
      if (state_q == ST_MAT) begin
        row_q <= '0;
      end else if (state_q == ST_EMIT && out_ready_i) begin
        row_q <= row_q + 1'b1;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_q[0] <= in_x_i; in_q[1] <= in_y_i; in_q[2] <= in_z_i; in_q[3] <= in_w_i;
    end
    if (state_q == ST_QMUL && step_q[1:0] == 2'd0) begin
      acc_q <= '0;
    end
    if (prod_v_q && state_q inside {ST_QMUL, ST_QSTORE}) begin
      if (pstep_q[1:0] == 2'd0) begin
        acc_q <= prod_ext;
      end else if (pstep_q[1:0] == 2'd3) begin
        tmp_q[pstep_q[3:2]] <= round_sat(acc_q + prod_ext);
      end else begin
        acc_q <= acc_q + prod_ext;
      end
    end
    if (state_q == ST_SUMSQ) begin
      if (step_q == StepW'(0)) begin
        sumsq_q <= '0;
      end else if (prod_v_q) begin
        sumsq_q <= sumsq_q + SqW'(prod_q);
      end
    end
    if (state_q == ST_SUMSQ && step_q == StepW'(5)) begin
      sq_rem_q <= sumsq_q;
      root_q   <= '0;
    end else if (state_q == ST_SQRT && sq_cnt_q != 5'd0) begin
      if (!sq_trial[SqW+1]) begin
        sq_rem_q <= sq_trial[SqW-1:0];
        root_q   <= {root_q[RootW-2:0], 1'b1};
      end else begin
        root_q   <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (prod_v_q && state_q == ST_MAT) begin
      mp_q[pstep_q] <= prod_q;
    end
    if (state_q == ST_MAT && step_q == StepW'(MSteps - 1)) begin
      mat_q[0] <= round_sat(one_q28 - x2(mp_q[0]) - x2(mp_q[1]));
      mat_q[1] <= round_sat(x2(mp_q[3]) + x2(mp_q[4]));
      mat_q[2] <= round_sat(x2(mp_q[5]) - x2(mp_q[6]));
      mat_q[3] <= round_sat(x2(mp_q[3]) - x2(mp_q[4]));
      mat_q[4] <= round_sat(one_q28 - x2(mp_q[1]) - x2(mp_q[2]));
      mat_q[5] <= round_sat(x2(mp_q[7]) + x2(mp_q[8]));
      mat_q[6] <= round_sat(x2(mp_q[5]) + x2(mp_q[6]));
      mat_q[7] <= round_sat(x2(mp_q[7]) - x2(mp_q[8]));
      mat_q[8] <= round_sat(one_q28 - x2(mp_q[0]) - x2(mp_q[2]));
    end
  end

  // Row selection: transposed form reads columns instead of rows.
  logic [3:0] ia, ib, ic;
  always_comb begin
    if (transpose_q) begin
      ia = 4'(row_q); ib = 4'(row_q) + 4'd3; ic = 4'(row_q) + 4'd6;
    end else begin
      ia = 4'(row_q) * 4'd3; ib = ia + 4'd1; ic = ia + 4'd2;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign row_index_o = row_q;
  assign col_a_o     = mat_q[ia];
  assign col_b_o     = mat_q[ib];
  assign col_c_o     = mat_q[ic];
  assign out_x_o     = ori_q[0];
  assign out_y_o     = ori_q[1];
  assign out_z_o     = ori_q[2];
  assign out_w_o     = ori_q[3];
  assign last_row_o  = (row_q == 2'd2);

  logic unused_cfg;
  assign unused_cfg = ^cfg_data_i[31:1];

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken during output");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_q != 2'd3) else $error("row index out of range");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_row_o |=> in_ready_o)
    else $error("block not idle after last row");
  a_ctr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == ST_QSTORE && state_q != ST_QSTORE |-> ctr_q <= interval_q)
    else $error("counter above interval after accumulation");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the quaternion rotation accumulator unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qra_pkg::*;

  // Each result transfer carries one matrix row and the current quaternion.
  typedef struct packed {
    logic [1:0] row;
    comp_t      ca, cb, cc;
    comp_t      qx, qy, qz, qw;
    logic       last;
  } row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, out_ready_i, cfg_valid_i;
  logic        in_ready_o, out_valid_o, cfg_ready_o, last_row_o;
  logic [1:0]  mode_i, row_index_o;
  comp_t       in_x_i, in_y_i, in_z_i, in_w_i;
  comp_t       col_a_o, col_b_o, col_c_o, out_x_o, out_y_o, out_z_o, out_w_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  quaternion_rotation_accumulator_unit u_top (.*);

  // Predictor state: orientation, counter and the two registers.
  comp_t        orient [4];
  logic [7:0]   acc_count;
  logic [7:0]   interval_reg;
  logic         transpose_reg;
  row_t         rows_pending [$];
  int unsigned  mismatches;
  int unsigned  cycles;
  int unsigned  burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic comp_t sat_comp(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return comp_t'(v);
  endfunction

  // Q4.28 to Q2.14 with a floor after adding half.
  function automatic comp_t round_q28(input longint v);
    return sat_comp((v + 8192) >>> 14);
  endfunction

  function automatic longint int_sqrt(input longint s);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  task automatic renormalise();
    longint s, m, mag, q;
    s = 0;
    for (int i = 0; i < 4; i++) s += longint'(orient[i]) * longint'(orient[i]);
    m = int_sqrt(s);
    if (m == 0) return;
    for (int i = 0; i < 4; i++) begin
      mag = (orient[i] < 0) ? -longint'(orient[i]) : longint'(orient[i]);
      q = (mag * 32768 + m) / (2 * m);
      orient[i] = sat_comp(orient[i] < 0 ? -q : q);
    end
  endtask

  // Applies one item to the predicted state and queues its three rows.
  task automatic predict_rows(input logic [1:0] mode, input comp_t qi [4]);
    longint ax, ay, az, aw, bx, by, bz, bw, a, b, c, d, one;
    comp_t  mt [3][3];
    row_t   r;
    ax = qi[0]; ay = qi[1]; az = qi[2]; aw = qi[3];
    bx = orient[0]; by = orient[1]; bz = orient[2]; bw = orient[3];
    case (mode)
      MODE_ACC: begin
        orient[0] = round_q28(bx * aw + ax * bw + (ay * bz - az * by));
        orient[1] = round_q28(by * aw + ay * bw + (az * bx - ax * bz));
        orient[2] = round_q28(bz * aw + az * bw + (ax * by - ay * bx));
        orient[3] = round_q28(aw * bw - (ax * bx + ay * by + az * bz));
        if ({1'b0, acc_count} + 9'd1 > {1'b0, interval_reg}) begin
          acc_count = '0;
          renormalise();
        end else begin
          acc_count = acc_count + 8'd1;
        end
      end
      MODE_LOAD: for (int i = 0; i < 4; i++) orient[i] = qi[i];
      MODE_CLEAR: begin
        orient[0] = '0; orient[1] = '0; orient[2] = '0; orient[3] = QOne;
      end
      default: ;
    endcase
    a = orient[0]; b = orient[1]; c = orient[2]; d = orient[3];
    one = longint'(1) <<< 28;
    mt[0][0] = round_q28(one - 2 * (b * b + c * c));
    mt[0][1] = round_q28(2 * (a * b + c * d));
    mt[0][2] = round_q28(2 * (c * a - b * d));
    mt[1][0] = round_q28(2 * (a * b - c * d));
    mt[1][1] = round_q28(one - 2 * (c * c + a * a));
    mt[1][2] = round_q28(2 * (b * c + a * d));
    mt[2][0] = round_q28(2 * (c * a + b * d));
    mt[2][1] = round_q28(2 * (b * c - a * d));
    mt[2][2] = round_q28(one - 2 * (b * b + a * a));
    for (int k = 0; k < 3; k++) begin
      r.row  = 2'(k);
      r.ca   = transpose_reg ? mt[0][k] : mt[k][0];
      r.cb   = transpose_reg ? mt[1][k] : mt[k][1];
      r.cc   = transpose_reg ? mt[2][k] : mt[k][2];
      r.qx   = orient[0]; r.qy = orient[1]; r.qz = orient[2]; r.qw = orient[3];
      r.last = (k == 2);
      rows_pending.push_back(r);
    end
  endtask

  // Sends one item, with bursts of random length separated by random gaps.
  // Within a burst valid stays high and the next payload follows at once.
  task automatic send_item(input logic [1:0] mode, input comp_t qi [4]);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= mode;
    in_x_i <= qi[0]; in_y_i <= qi[1]; in_z_i <= qi[2]; in_w_i <= qi[3];
    do @(posedge clk_i); while (!in_ready_o);
    predict_rows(mode, qi);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // Configuration is written only once the block is idle.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == 8'(CFG_INTERVAL)) interval_reg = data[7:0];
    else if (idx == 8'(CFG_TRANSPOSE)) transpose_reg = data[0];
    cfg_valid_i <= 1'b0;
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return comp_t'($urandom_range(0, 32767) - 16384);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic send_quat(input logic [1:0] mode, input int x, y, z, w);
    comp_t qi [4];
    qi[0] = comp_t'(x); qi[1] = comp_t'(y); qi[2] = comp_t'(z); qi[3] = comp_t'(w);
    send_item(mode, qi);
  endtask

  // Extremes, every mode and the zero-magnitude renormalisation.
  task automatic test_directed();
    send_quat(MODE_KEEP, 1, 2, 3, 4);
    send_quat(MODE_ACC, 0, 0, 0, 16384);
    send_quat(MODE_ACC, 11585, 0, 0, 11585);
    send_quat(MODE_LOAD, 32767, -32768, 32767, -32768);
    send_quat(MODE_ACC, -32768, 32767, -32768, 32767);
    send_quat(MODE_CLEAR, -1, -1, -1, -1);
    send_quat(MODE_LOAD, 0, 0, 0, 0);
    send_quat(MODE_ACC, 100, 200, 300, 400);
    send_quat(MODE_LOAD, 8000, -8000, 8000, 8000);
    send_quat(MODE_KEEP, -32768, -32768, -32768, -32768);
    send_quat(MODE_ACC, 0, 11585, 0, 11585);
    send_quat(MODE_CLEAR, 32767, 32767, 32767, 32767);
  endtask

  // Random content; interval settings exercise renormalisation often.
  task automatic test_random(input int n);
    comp_t qi [4];
    logic [1:0] mode;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 4; i++) qi[i] = rand_comp();
      mode = ($urandom_range(0, 9) < 6) ? MODE_ACC : 2'($urandom);
      send_item(mode, qi);
    end
  endtask

  // Lowering the interval below the running count forces a renormalisation.
  task automatic test_interval_lowered();
    write_reg(8'(CFG_INTERVAL), 32'd50);
    test_random(8);
    write_reg(8'(CFG_INTERVAL), 32'd1);
    test_random(4);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; mode_i = '0;
    in_x_i = '0; in_y_i = '0; in_z_i = '0; in_w_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    orient[0] = '0; orient[1] = '0; orient[2] = '0; orient[3] = QOne;
    acc_count = '0;
    interval_reg = IntervalReset;
    transpose_reg = 1'b0;
    mismatches = 0;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(8'(CFG_TRANSPOSE), 32'd1);
    write_reg(8'(CFG_INTERVAL), 32'd0);
    test_directed();
    test_random(60);
    test_interval_lowered();
    write_reg(8'(CFG_TRANSPOSE), 32'hfffffffe);
    write_reg(8'(CFG_INTERVAL), 32'd255);
    write_reg(8'd7, 32'd3);
    test_random(50);
    write_reg(8'(CFG_INTERVAL), 32'd3);
    test_random(70);
    write_reg(8'(CFG_TRANSPOSE), 32'd1);
    test_random(50);
    wait_drained();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // The receiver stalls on a slowly drifting pattern of its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (cycles[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Compares each accepted row with the oldest expectation.
  always @(posedge clk_i) begin
    row_t got, exp_row;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{row_index_o, col_a_o, col_b_o, col_c_o,
              out_x_o, out_y_o, out_z_o, out_w_o, last_row_o};
      if (rows_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected row transfer: %p", got);
      end else begin
        exp_row = rows_pending.pop_front();
        if (got !== exp_row) begin
          mismatches++;
          if (mismatches <= 10) $display("Row mismatch: expected %p, got %p", exp_row, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial cycles = 0;
endmodule

/* files.f */
src/qra_pkg.sv
src/qra_div.sv
src/quaternion_rotation_accumulator_unit.sv
verif/testbench.sv
